[rtl/core/supply_rail_monitor_trip_core_defines.svh]
// Assertion macros shared by the supply rail monitor RTL.
// No dependencies; pulled in by the top level.
`ifndef SUPPLY_RAIL_MONITOR_TRIP_CORE_DEFINES_SVH
`define SUPPLY_RAIL_MONITOR_TRIP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SRM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srm: same-cycle rule violated");

// next-cycle implication, disabled during reset
`define SRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srm: next-cycle rule violated");

`endif

[rtl/core/srm_pkg.sv]
// Shared types, widths and scaling constants for the supply rail monitor.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package srm_pkg;

  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int NUM_CH   = 5;
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int AVG_W    = 16;
  localparam int LIMIT_W  = 16;
  localparam int CHECKS_W = 8;

  // APB side
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // average = sum * recip >> AVG_SHIFT, exact for any 16-bit sum and depth <= 32
  localparam int AVG_SHIFT   = 21;
  localparam int AVG_RECIP_W = AVG_SHIFT + 1;
  localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

  // 25 V: avg * 67925 / 9216 = ((avg * 67925) >> 10) / 9
  localparam int V25_MUL       = 67925;
  localparam int V25_MUL_W     = 17;
  localparam int V25_PRE_SHIFT = 10;
  localparam int V25_DIV       = 9216 / 1024;
  localparam int P25_W         = AVG_W + V25_MUL_W;
  localparam int Q25_W         = P25_W - V25_PRE_SHIFT;
  localparam int DIV_SHIFT     = 27;
  localparam int DIV_RECIP     = (2 ** DIV_SHIFT + V25_DIV - 1) / V25_DIV;
  localparam int DIV_RECIP_W   = 24;
  localparam int DIV_PROD_W    = Q25_W + DIV_RECIP_W;

  localparam int V12_MUL   = 3575;
  localparam int V12_SHIFT = 10;
  localparam int V12_P_W   = AVG_W + 12;
  localparam int V12_W     = V12_P_W - V12_SHIFT;

  localparam int V5_MUL   = 715;
  localparam int V5_SHIFT = 9;
  localparam int V5_P_W   = AVG_W + 10;
  localparam int V5_W     = V5_P_W - V5_SHIFT;

  localparam int CUR_MUL   = 165;
  localparam int CUR_SHIFT = 7;
  localparam int CUR_P_W   = AVG_W + 8;
  localparam int CUR_W     = CUR_P_W - CUR_SHIFT;

  // result field widths
  localparam int VOLT25_W  = 15;
  localparam int VOLT12_W  = 14;
  localparam int VOLT5_W   = 13;
  localparam int CURR_W    = 13;
  localparam int OUT_DATA_W = 72;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CHECK  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_HIGH_12V  = 3'd0,
    REG_LOW_12V   = 3'd1,
    REG_MAX_12V_I = 3'd2,
    REG_HIGH_5V   = 3'd3,
    REG_LOW_5V    = 3'd4,
    REG_MAX_5V_I  = 3'd5,
    REG_OC_CHECKS = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]  high_12v;
    logic [LIMIT_W-1:0]  low_12v;
    logic [LIMIT_W-1:0]  max_12v_i;
    logic [LIMIT_W-1:0]  high_5v;
    logic [LIMIT_W-1:0]  low_5v;
    logic [LIMIT_W-1:0]  max_5v_i;
    logic [CHECKS_W-1:0] oc_checks;
  } cfg_t;

  typedef struct packed {
    logic [Q25_W-1:0] q25;
    logic [V12_W-1:0] v12;
    logic [V5_W-1:0]  v5;
    logic [CUR_W-1:0] i12;
    logic [CUR_W-1:0] i5;
  } scaled_t;

  typedef struct packed {
    logic [VOLT25_W-1:0] volt_25;
    logic [VOLT12_W-1:0] volt_12;
    logic [VOLT5_W-1:0]  volt_5;
    logic [CURR_W-1:0]   curr_12;
    logic [CURR_W-1:0]   curr_5;
    logic                trip_12v;
    logic                trip_5v;
  } result_t;

endpackage

[rtl/core/supply_rail_monitor_trip_core.sv]
// Top level of the supply rail monitor: window sums, scaler, trip logic, registers.
// Depends on srm_pkg, srm_cfg_regs, srm_window, srm_scale, srm_trip and the defines header.
//
//   port group  dir     word contents
//   in_*        slave   tdata: sample; tuser: cmd, channel
//   out_*       master  tdata: volt_25, volt_12, volt_5, curr_12, curr_5, trip_12v, trip_5v
//   cfg_*       APB     seven limit registers at byte offsets 0x00..0x18
//
// One word per cycle on the input while no check waits; sample words finish in the input register.
// A check word passes the input, average, scale and result registers in turn to reach out_*.
// Synchronous reset (rst_n low) clears sample lines, sums, run count, valid flags; registers get defaults.
// Each stage holds while the next is full; bubbles close up, so input is taken while a result waits.
`timescale 1ns / 1ps
`include "supply_rail_monitor_trip_core_defines.svh"

module supply_rail_monitor_trip_core #(
  parameter int WINDOW_DEPTH = srm_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = srm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [srm_pkg::IN_DATA_W-1:0]    in_tdata,   // [11:0] sample, rest zero
  input  logic [srm_pkg::IN_USER_W-1:0]    in_tuser,   // [0] cmd, [3:1] channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [14:0] volt_25, [28:15] volt_12, [41:29] volt_5, [54:42] curr_12,
  // [67:55] curr_5, [68] trip_12v, [69] trip_5v, [71:70] zero
  output logic [srm_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [srm_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [srm_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [srm_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  srm_pkg::cfg_t                                    cfg;
  logic                                             chk_valid;
  logic                                             chk_ready;
  logic [srm_pkg::NUM_CH-1:0][srm_pkg::SUM_W-1:0]   chk_sum;
  logic                                             scl_valid;
  logic                                             scl_ready;
  srm_pkg::scaled_t                                 scl;
  srm_pkg::result_t                                 res;

  srm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  srm_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (srm_pkg::cmd_t'(in_tuser[0])),
    .in_channel (in_tuser[srm_pkg::CH_W:1]),
    .in_sample  (in_tdata[srm_pkg::SAMPLE_W-1:0]),
    .chk_valid  (chk_valid),
    .chk_ready  (chk_ready),
    .chk_sum    (chk_sum)
  );

  srm_scale #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .chk_valid (chk_valid),
    .chk_ready (chk_ready),
    .chk_sum   (chk_sum),
    .scl_valid (scl_valid),
    .scl_ready (scl_ready),
    .scl       (scl)
  );

  srm_trip u_trip (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .scl_valid (scl_valid),
    .scl_ready (scl_ready),
    .scl       (scl),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.trip_5v, res.trip_12v, res.curr_5, res.curr_12,
                      res.volt_5, res.volt_12, res.volt_25};

  // an empty result register must let the whole pipe, and the input, move
  `SRM_ASSERT_IMPLY(a_idle_out_takes_input, clk, rst_n, !out_tvalid, in_tready)
  // a word leaving the scaler lands in the result register
  `SRM_ASSERT_NEXT(a_scaled_reaches_out, clk, rst_n, scl_valid && scl_ready, out_tvalid)
  // a check held in the input register stays until the scaler takes it
  `SRM_ASSERT_NEXT(a_check_held, clk, rst_n, chk_valid && !chk_ready, chk_valid)

endmodule

[rtl/core/srm_cfg_regs.sv]
// APB-style register file holding the rail limits and the overcurrent run length.
// Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srm_pkg::ADDR_W-1:0]   paddr,
  input  logic [srm_pkg::DATA_W-1:0]   pwdata,
  output logic [srm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output srm_pkg::cfg_t                cfg
);

  srm_pkg::cfg_t     cfg_r;
  srm_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = srm_pkg::reg_idx_t'(paddr[srm_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_12v  <= 16'd13530;
      cfg_r.low_12v   <= 16'd11070;
      cfg_r.max_12v_i <= 16'd7000;
      cfg_r.high_5v   <= 16'd6600;
      cfg_r.low_5v    <= 16'd4800;
      cfg_r.max_5v_i  <= 16'd1000;
      cfg_r.oc_checks <= 8'd3;
    end else if (wr_en) begin
      case (idx)
        srm_pkg::REG_HIGH_12V:  cfg_r.high_12v  <= pwdata[srm_pkg::LIMIT_W-1:0];
        srm_pkg::REG_LOW_12V:   cfg_r.low_12v   <= pwdata[srm_pkg::LIMIT_W-1:0];
        srm_pkg::REG_MAX_12V_I: cfg_r.max_12v_i <= pwdata[srm_pkg::LIMIT_W-1:0];
        srm_pkg::REG_HIGH_5V:   cfg_r.high_5v   <= pwdata[srm_pkg::LIMIT_W-1:0];
        srm_pkg::REG_LOW_5V:    cfg_r.low_5v    <= pwdata[srm_pkg::LIMIT_W-1:0];
        srm_pkg::REG_MAX_5V_I:  cfg_r.max_5v_i  <= pwdata[srm_pkg::LIMIT_W-1:0];
        srm_pkg::REG_OC_CHECKS: cfg_r.oc_checks <= pwdata[srm_pkg::CHECKS_W-1:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      srm_pkg::REG_HIGH_12V:  prdata = srm_pkg::DATA_W'(cfg_r.high_12v);
      srm_pkg::REG_LOW_12V:   prdata = srm_pkg::DATA_W'(cfg_r.low_12v);
      srm_pkg::REG_MAX_12V_I: prdata = srm_pkg::DATA_W'(cfg_r.max_12v_i);
      srm_pkg::REG_HIGH_5V:   prdata = srm_pkg::DATA_W'(cfg_r.high_5v);
      srm_pkg::REG_LOW_5V:    prdata = srm_pkg::DATA_W'(cfg_r.low_5v);
      srm_pkg::REG_MAX_5V_I:  prdata = srm_pkg::DATA_W'(cfg_r.max_5v_i);
      srm_pkg::REG_OC_CHECKS: prdata = srm_pkg::DATA_W'(cfg_r.oc_checks);
      default:                prdata = '0;
    endcase
  end

endmodule

[rtl/core/srm_window.sv]
// Input register, per-channel sample shift lines and running window sums.
// Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_window #(
  parameter int WINDOW_DEPTH = srm_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = srm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  srm_pkg::cmd_t                                    in_cmd,
  input  logic [srm_pkg::CH_W-1:0]                         in_channel,
  input  logic [srm_pkg::SAMPLE_W-1:0]                     in_sample,
  output logic                                             chk_valid,
  input  logic                                             chk_ready,
  output logic [srm_pkg::NUM_CH-1:0][srm_pkg::SUM_W-1:0]   chk_sum
);

  logic                       word_vld_r;
  srm_pkg::cmd_t              cmd_r;
  logic [srm_pkg::CH_W-1:0]   ch_r;
  logic [SAMPLE_BITS-1:0]     smp_r;
  logic                       leave;
  logic                       store;

  // a sample word never stalls in the input register; a check waits for the scaler
  assign leave     = word_vld_r && ((cmd_r == srm_pkg::CMD_SAMPLE) || chk_ready);
  assign in_ready  = !word_vld_r || leave;
  assign chk_valid = word_vld_r && (cmd_r == srm_pkg::CMD_CHECK);
  assign store     = word_vld_r && (cmd_r == srm_pkg::CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= 1'b0;
    end else if (in_ready) begin
      word_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd;
      ch_r  <= in_channel;
      smp_r <= in_sample[SAMPLE_BITS-1:0];
    end
  end

  for (genvar c = 0; c < srm_pkg::NUM_CH; c++) begin : g_ch
    logic [WINDOW_DEPTH-1:0][SAMPLE_BITS-1:0] line_r;
    logic [srm_pkg::SUM_W-1:0]                sum_r;
    logic [srm_pkg::SUM_W-1:0]                sum_nxt;
    logic                                     hit;

    assign hit     = store && (ch_r == srm_pkg::CH_W'(c));
    // oldest sample falls off the end of the line and out of the sum
    assign sum_nxt = sum_r - srm_pkg::SUM_W'(line_r[WINDOW_DEPTH-1])
                     + srm_pkg::SUM_W'(smp_r);
    assign chk_sum[c] = sum_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        line_r <= '0;
        sum_r  <= '0;
      end else if (hit) begin
        line_r[0] <= smp_r;
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
          line_r[k] <= line_r[k-1];
        end
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

[rtl/core/srm_scale.sv]
// Two-stage scaler: window average by reciprocal, then fixed-ratio scaling.
// Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_scale #(
  parameter int WINDOW_DEPTH = srm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             chk_valid,
  output logic                                             chk_ready,
  input  logic [srm_pkg::NUM_CH-1:0][srm_pkg::SUM_W-1:0]   chk_sum,
  output logic                                             scl_valid,
  input  logic                                             scl_ready,
  output srm_pkg::scaled_t                                 scl
);

  localparam logic [srm_pkg::AVG_RECIP_W-1:0] AvgRecip =
    srm_pkg::AVG_RECIP_W'((2 ** srm_pkg::AVG_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

  logic                                               avg_vld_r;
  logic [srm_pkg::NUM_CH-1:0][srm_pkg::AVG_W-1:0]     avg_r;
  logic [srm_pkg::NUM_CH-1:0][srm_pkg::AVG_W-1:0]     avg_nxt;
  logic                                               scl_vld_r;
  srm_pkg::scaled_t                                   scl_r;
  srm_pkg::scaled_t                                   scl_nxt;
  logic                                               c_rdy;

  assign c_rdy     = !scl_vld_r || scl_ready;
  assign chk_ready = !avg_vld_r || c_rdy;
  assign scl_valid = scl_vld_r;
  assign scl       = scl_r;

  always_comb begin
    logic [srm_pkg::AVG_PROD_W-1:0] prod;
    prod = '0;
    for (int c = 0; c < srm_pkg::NUM_CH; c++) begin
      prod       = srm_pkg::AVG_PROD_W'(chk_sum[c]) * srm_pkg::AVG_PROD_W'(AvgRecip);
      avg_nxt[c] = prod[srm_pkg::AVG_SHIFT +: srm_pkg::AVG_W];
    end
  end

  always_comb begin
    logic [srm_pkg::P25_W-1:0]   p25;
    logic [srm_pkg::V12_P_W-1:0] p12;
    logic [srm_pkg::V5_P_W-1:0]  p5;
    logic [srm_pkg::CUR_P_W-1:0] pi12;
    logic [srm_pkg::CUR_P_W-1:0] pi5;
    p25  = srm_pkg::P25_W'(avg_r[0]) * srm_pkg::P25_W'(srm_pkg::V25_MUL);
    p12  = srm_pkg::V12_P_W'(avg_r[1]) * srm_pkg::V12_P_W'(srm_pkg::V12_MUL);
    p5   = srm_pkg::V5_P_W'(avg_r[2]) * srm_pkg::V5_P_W'(srm_pkg::V5_MUL);
    pi12 = srm_pkg::CUR_P_W'(avg_r[3]) * srm_pkg::CUR_P_W'(srm_pkg::CUR_MUL);
    pi5  = srm_pkg::CUR_P_W'(avg_r[4]) * srm_pkg::CUR_P_W'(srm_pkg::CUR_MUL);
    // 25 V keeps its divide by nine for the next stage
    scl_nxt.q25 = p25[srm_pkg::V25_PRE_SHIFT +: srm_pkg::Q25_W];
    scl_nxt.v12 = p12[srm_pkg::V12_SHIFT +: srm_pkg::V12_W];
    scl_nxt.v5  = p5[srm_pkg::V5_SHIFT +: srm_pkg::V5_W];
    scl_nxt.i12 = pi12[srm_pkg::CUR_SHIFT +: srm_pkg::CUR_W];
    scl_nxt.i5  = pi5[srm_pkg::CUR_SHIFT +: srm_pkg::CUR_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_vld_r <= 1'b0;
      scl_vld_r <= 1'b0;
    end else begin
      if (chk_ready) begin
        avg_vld_r <= chk_valid;
      end
      if (c_rdy) begin
        scl_vld_r <= avg_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_valid && chk_ready) begin
      avg_r <= avg_nxt;
    end
    if (avg_vld_r && c_rdy) begin
      scl_r <= scl_nxt;
    end
  end

endmodule

[rtl/core/srm_trip.sv]
// Trip decisions, overcurrent run counter and the result register.
// Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_trip (
  input  logic              clk,
  input  logic              rst_n,
  input  srm_pkg::cfg_t     cfg,
  input  logic              scl_valid,
  output logic              scl_ready,
  input  srm_pkg::scaled_t  scl,
  output logic              res_valid,
  input  logic              res_ready,
  output srm_pkg::result_t  res
);

  logic                            res_vld_r;
  srm_pkg::result_t                res_r;
  srm_pkg::result_t                res_nxt;
  logic [srm_pkg::CHECKS_W-1:0]    run_r;
  logic [srm_pkg::CHECKS_W-1:0]    run_nxt;
  logic                            take;

  assign scl_ready = !res_vld_r || res_ready;
  assign take      = scl_valid && scl_ready;
  assign res_valid = res_vld_r;
  assign res       = res_r;

  always_comb begin
    logic [srm_pkg::DIV_PROD_W-1:0] p25;
    logic                           v12_bad;
    logic                           v5_bad;
    logic                           i5_over;
    logic [srm_pkg::CHECKS_W-1:0]   run_inc;
    p25 = srm_pkg::DIV_PROD_W'(scl.q25) * srm_pkg::DIV_PROD_W'(srm_pkg::DIV_RECIP);
    v12_bad = (scl.v12 > srm_pkg::V12_W'(cfg.high_12v)) ||
              (scl.v12 < srm_pkg::V12_W'(cfg.low_12v)) ||
              (scl.i12 > srm_pkg::CUR_W'(cfg.max_12v_i));
    v5_bad  = (scl.v5 > srm_pkg::V5_W'(cfg.high_5v)) ||
              (scl.v5 < srm_pkg::V5_W'(cfg.low_5v));
    i5_over = scl.i5 > srm_pkg::CUR_W'(cfg.max_5v_i);
    run_inc = run_r + 8'd1;

    res_nxt.volt_25  = p25[srm_pkg::DIV_SHIFT +: srm_pkg::VOLT25_W];
    res_nxt.volt_12  = scl.v12[srm_pkg::VOLT12_W-1:0];
    res_nxt.volt_5   = scl.v5[srm_pkg::VOLT5_W-1:0];
    res_nxt.curr_12  = scl.i12[srm_pkg::CURR_W-1:0];
    res_nxt.curr_5   = scl.i5[srm_pkg::CURR_W-1:0];
    res_nxt.trip_12v = v12_bad;

    // 5 V: voltage fault wins; an over-limit current counts toward a run, tripping once it reaches oc_checks
    if (v5_bad) begin
      res_nxt.trip_5v = 1'b1;
      run_nxt         = '0;
    end else if (i5_over) begin
      if (run_inc >= cfg.oc_checks) begin
        res_nxt.trip_5v = 1'b1;
        run_nxt         = '0;
      end else begin
        res_nxt.trip_5v = 1'b0;
        run_nxt         = run_inc;
      end
    end else begin
      res_nxt.trip_5v = 1'b0;
      run_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      run_r     <= '0;
    end else begin
      if (scl_ready) begin
        res_vld_r <= scl_valid;
      end
      if (take) begin
        run_r <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

[test/supply_rail_monitor_trip_core_tb.sv]
// Self-checking testbench for supply_rail_monitor_trip_core: sample and check words in,
// rail readings out, limit registers over APB. Needs srm_pkg and the core RTL only.
`timescale 1ns / 1ps

module supply_rail_monitor_trip_core_tb;
  import srm_pkg::*;

  localparam int WINDOW         = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  localparam cfg_t RESET_LIMITS = '{high_12v: 16'd13530, low_12v: 16'd11070,
                                   max_12v_i: 16'd7000, high_5v: 16'd6600,
                                   low_5v: 16'd4800, max_5v_i: 16'd1000,
                                   oc_checks: 8'd3};

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  channel;
    logic [11:0] sample;
  } rail_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [11:0] sample, [15:12] zero
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] cmd, [3:1] channel
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  // [14:0] volt_25, [28:15] volt_12, [41:29] volt_5, [54:42] curr_12,
  // [67:55] curr_5, [68] trip_12v, [69] trip_5v
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [DATA_W-1:0]     cfg_pwdata = '0;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  supply_rail_monitor_trip_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's state
  cfg_t        limits;
  logic [11:0] window_store [WINDOW][NUM_CH];
  int unsigned window_slot [NUM_CH];
  logic [15:0] window_sum [NUM_CH];
  logic [7:0]  oc_run;

  rail_word_t  queued_words[$];
  result_t     expected_readings[$];
  rail_word_t  word_on_bus;
  int unsigned words_submitted = 0;
  int unsigned words_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;
  result_t     seen_reading;
  result_t     want_reading;

  function automatic void track_rail_word(input rail_word_t w);
    int unsigned slot;
    int unsigned avg [NUM_CH];
    int unsigned v25, v12, v5, i12, i5;
    result_t r;
    if (w.cmd == CMD_SAMPLE) begin
      if (w.channel < NUM_CH) begin
        slot = window_slot[w.channel];
        window_sum[w.channel] = window_sum[w.channel] - window_store[slot][w.channel]
                                + w.sample;
        window_store[slot][w.channel] = w.sample;
        window_slot[w.channel] = (slot + 1 == WINDOW) ? 0 : slot + 1;
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++) avg[c] = window_sum[c] / WINDOW;
      v25 = avg[0] * 67925 / 9216;
      v12 = avg[1] * 3575 / 1024;
      v5  = avg[2] * 715 / 512;
      i12 = avg[3] * 165 / 128;
      i5  = avg[4] * 165 / 128;
      r.volt_25  = 15'(v25);
      r.volt_12  = 14'(v12);
      r.volt_5   = 13'(v5);
      r.curr_12  = 13'(i12);
      r.curr_5   = 13'(i5);
      r.trip_12v = (v12 > limits.high_12v) || (v12 < limits.low_12v) ||
                   (i12 > limits.max_12v_i);
      r.trip_5v  = 1'b0;
      if (v5 > limits.high_5v || v5 < limits.low_5v) begin
        r.trip_5v = 1'b1;
        oc_run = '0;
      end else if (i5 > limits.max_5v_i) begin
        oc_run = oc_run + 8'd1;
        // a run length of zero acts as one
        if (oc_run >= limits.oc_checks) begin
          r.trip_5v = 1'b1;
          oc_run = '0;
        end
      end else begin
        oc_run = '0;
      end
      expected_readings.push_back(r);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_rail_word(word_on_bus);
        words_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (queued_words.size() > 0) begin
          word_on_bus = queued_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0000, word_on_bus.sample};
          in_tuser  <= {word_on_bus.channel, word_on_bus.cmd};
          if (!steady && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_reading.volt_25  = out_tdata[14:0];
      seen_reading.volt_12  = out_tdata[28:15];
      seen_reading.volt_5   = out_tdata[41:29];
      seen_reading.curr_12  = out_tdata[54:42];
      seen_reading.curr_5   = out_tdata[67:55];
      seen_reading.trip_12v = out_tdata[68];
      seen_reading.trip_5v  = out_tdata[69];
      if (expected_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected reading: v25=%0d v12=%0d v5=%0d i12=%0d i5=%0d t12=%0b t5=%0b",
                   seen_reading.volt_25, seen_reading.volt_12, seen_reading.volt_5,
                   seen_reading.curr_12, seen_reading.curr_5, seen_reading.trip_12v,
                   seen_reading.trip_5v);
        mismatch_count++;
      end else begin
        want_reading = expected_readings.pop_front();
        if (seen_reading !== want_reading) begin
          if (mismatch_count < 10) begin
            $display("reading mismatch: expected v25=%0d v12=%0d v5=%0d i12=%0d i5=%0d t12=%0b t5=%0b",
                     want_reading.volt_25, want_reading.volt_12, want_reading.volt_5,
                     want_reading.curr_12, want_reading.curr_5, want_reading.trip_12v,
                     want_reading.trip_5v);
            $display("                  actual   v25=%0d v12=%0d v5=%0d i12=%0d i5=%0d t12=%0b t5=%0b",
                     seen_reading.volt_25, seen_reading.volt_12, seen_reading.volt_5,
                     seen_reading.curr_12, seen_reading.curr_5, seen_reading.trip_12v,
                     seen_reading.trip_5v);
          end
          mismatch_count++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[supply_rail_monitor_trip_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input cmd_t cmd, input logic [2:0] channel,
                           input logic [11:0] sample);
    rail_word_t w;
    w.cmd = cmd;
    w.channel = channel;
    w.sample = sample;
    queued_words.push_back(w);
    words_submitted++;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_HIGH_12V:  limits.high_12v  = value[15:0];
      REG_LOW_12V:   limits.low_12v   = value[15:0];
      REG_MAX_12V_I: limits.max_12v_i = value[15:0];
      REG_HIGH_5V:   limits.high_5v   = value[15:0];
      REG_LOW_5V:    limits.low_5v    = value[15:0];
      REG_MAX_5V_I:  limits.max_5v_i  = value[15:0];
      REG_OC_CHECKS: limits.oc_checks = value[7:0];
      default: ;
    endcase
  endtask

  // junk in the upper bits must not reach the registers
  task automatic program_limits(input cfg_t c);
    write_register(REG_HIGH_12V,  {16'($urandom), c.high_12v});
    write_register(REG_LOW_12V,   {16'($urandom), c.low_12v});
    write_register(REG_MAX_12V_I, {16'($urandom), c.max_12v_i});
    write_register(REG_HIGH_5V,   {16'($urandom), c.high_5v});
    write_register(REG_LOW_5V,    {16'($urandom), c.low_5v});
    write_register(REG_MAX_5V_I,  {16'($urandom), c.max_5v_i});
    write_register(REG_OC_CHECKS, {24'($urandom), c.oc_checks});
  endtask

  function automatic cfg_t pick_limits(input int phase);
    cfg_t c;
    c = RESET_LIMITS;
    case (phase)
      0: c.oc_checks = 8'd1;
      1: c = '0;
      2: begin
        c = '1;
        c.oc_checks = 8'd255;
      end
      3: begin
        c.high_12v  = 16'(13000 + $urandom_range(0, 1000));
        c.low_12v   = 16'(10800 + $urandom_range(0, 800));
        c.max_12v_i = 16'($urandom_range(1500, 5300));
        c.high_5v   = 16'(6000 + $urandom_range(0, 800));
        c.low_5v    = 16'(4700 + $urandom_range(0, 600));
        c.max_5v_i  = 16'(800 + $urandom_range(0, 400));
        c.oc_checks = 8'($urandom_range(1, 6));
      end
      4: begin
        c = cfg_t'({$urandom, $urandom, $urandom, 8'($urandom)});
        c.max_12v_i = 16'($urandom_range(0, 6000));
      end
      default: c.oc_checks = 8'd2;
    endcase
    return c;
  endfunction

  // traffic: each channel hovers around a level that shifts every episode, plus stray samples to channels 5..7
  task automatic queue_rail_traffic(input int count);
    int unsigned lo [NUM_CH];
    int unsigned hi [NUM_CH];
    int unsigned level [NUM_CH];
    int done;
    int ch;
    int v;
    lo = '{0, 3150, 3400, 0, 650};
    hi = '{4095, 3900, 4095, 4095, 1000};
    done = 0;
    while (done < count) begin
      if (done % 80 == 0) begin
        for (int c = 0; c < NUM_CH; c++) begin
          case ($urandom_range(0, 3))
            2:       level[c] = $urandom_range(0, 4095);
            3:       level[c] = $urandom_range(0, 1) ? 4095 : 0;
            default: level[c] = $urandom_range(lo[c], hi[c]);
          endcase
        end
      end
      case ($urandom_range(0, 99)) inside
        [0:14]: begin
          push_word(CMD_CHECK, 3'($urandom), 12'($urandom));
          done++;
        end
        [15:17]: push_word(CMD_SAMPLE, 3'($urandom_range(5, 7)), 12'($urandom));
        default: begin
          ch = $urandom_range(0, NUM_CH - 1);
          v = int'(level[ch]) + $urandom_range(0, 80) - 40;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          push_word(CMD_SAMPLE, 3'(ch), 12'(v));
          done++;
        end
      endcase
    end
  endtask

  task automatic drain_words();
    while (words_accepted != words_submitted || expected_readings.size() != 0)
      @(posedge clk);
    // sample words leave no reading; let them settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    limits = RESET_LIMITS;
    oc_run = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      window_slot[c] = 0;
      window_sum[c] = '0;
      for (int s = 0; s < WINDOW; s++) window_store[s][c] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty windows, ignored channels, window wrap on the 12 V channel
    push_word(CMD_CHECK, 3'd7, 12'hFFF);
    push_word(CMD_SAMPLE, 3'd0, 12'hFFF);
    push_word(CMD_SAMPLE, 3'd5, 12'hFFF);
    push_word(CMD_SAMPLE, 3'd6, 12'h000);
    push_word(CMD_SAMPLE, 3'd7, 12'hFFF);
    push_word(CMD_SAMPLE, 3'd1, 12'hFFF);
    repeat (10) push_word(CMD_SAMPLE, 3'd1, 12'd3500);
    push_word(CMD_SAMPLE, 3'd2, 12'hFFF);
    push_word(CMD_SAMPLE, 3'd3, 12'hFFF);
    push_word(CMD_SAMPLE, 3'd4, 12'hFFF);
    push_word(CMD_CHECK, 3'd0, 12'h000);
    push_word(CMD_CHECK, 3'd4, 12'h5A5);
    push_word(CMD_CHECK, 3'd2, 12'hA5A);
    drain_words();

    for (int phase = 0; phase < 6; phase++) begin
      program_limits(pick_limits(phase));
      if (phase == 0) write_register(REG_UNMAPPED, $urandom);
      steady = (phase == 5);
      queue_rail_traffic(125);
      drain_words();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("[supply_rail_monitor_trip_core] OK");
    end else begin
      $display("[supply_rail_monitor_trip_core] ERROR");
    end
    $finish;
  end

endmodule
